// ----- rtl/core/sdiwb_pkg.sv -----
// shared types, constants and fixed point helpers for the sphere step pipeline
package sdiwb_pkg;

   localparam int NSTAGE    = 42;
   localparam int DIV_FIRST = 4;
   localparam int DIV_BITS  = 31;
   localparam int AXES      = 3;

   localparam logic [30:0] POS_MAX31 = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      REG_GRAVITY_X     = 3'd0,
      REG_GRAVITY_Y     = 3'd1,
      REG_GRAVITY_Z     = 3'd2,
      REG_FLUID_DENSITY = 3'd3,
      REG_STEP_TIME     = 3'd4,
      REG_BOX_HALF_SIZE = 3'd5,
      REG_WALL_MARGIN   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        body_mass;
      logic [30:0]        body_radius;
      logic [30:0]        drag_coef;
      logic [30:0]        frontal_area;
      logic [16:0]        restitution;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic [2:0]         wall_hits;
   } rsp_type;

   // per axis working set carried down the pipe
   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] acc;
      logic [31:0]        apos;
      logic signed [32:0] far;
      logic               hit;
      logic               bnc;
      logic [63:0]        prod;
      logic [30:0]        f;
      logic [30:0]        nsh;
      logic [31:0]        rem;
      logic [30:0]        quo;
      logic               fz;
      logic               ovf;
   } lane_type;

   typedef struct packed {
      logic        valid;
      logic [30:0] mass;
      logic [30:0] area;
      logic [16:0] cr;
      logic [61:0] prod;
   } common_type;

   typedef struct packed {
      common_type           c;
      lane_type [AXES-1:0]  lane;
   } stage_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      mag32 = a[31] ? 32'(-a) : 32'(a);
   endfunction

   function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
      if (v > 36'sh0_7FFF_FFFF)
         sat36 = 32'sh7FFF_FFFF;
      else if (v < -36'sh0_8000_0000)
         sat36 = 32'sh8000_0000;
      else
         sat36 = v[31:0];
   endfunction

   // finish a sign-magnitude product: drop fraction, clamp, apply sign
   function automatic logic signed [31:0] qmul_finish(input logic neg,
                                                      input logic [63:0] prod);
      logic [47:0] p;
      p = prod[63:16];
      if (neg)
         qmul_finish = (p > 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(p[31:0]);
      else
         qmul_finish = (|p[47:31]) ? 32'sh7FFF_FFFF : $signed(p[31:0]);
   endfunction

endpackage

// ----- rtl/core/sphere_drag_integrate_wall_bounce_top.sv -----
// sphere step: semi-implicit euler update (position advanced with the new velocity) with quadratic drag and wall bounce
// throughput: one request per cycle; the 31 stage restoring divider per axis sets the depth
// busy stays low, every request flows straight down the pipe
// synchronous reset clears the stage valid bits and loads the register defaults
module sphere_drag_integrate_wall_bounce_top
   import sdiwb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic signed [31:0] grav_ff [AXES];
   logic [30:0] rho_ff, dt_ff, box_ff, margin_ff;

   stage_type st_ff [NSTAGE];
   stage_type st_in [NSTAGE];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff[0] <= 32'sd0;
         grav_ff[1] <= 32'sd0;
         grav_ff[2] <= -32'sd642252;
         rho_ff     <= 31'd80282;
         dt_ff      <= 31'd66;
         box_ff     <= 31'd327680;
         margin_ff  <= 31'd655;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GRAVITY_X:     grav_ff[0] <= csr_data;
            REG_GRAVITY_Y:     grav_ff[1] <= csr_data;
            REG_GRAVITY_Z:     grav_ff[2] <= csr_data;
            REG_FLUID_DENSITY: rho_ff     <= csr_data[30:0];
            REG_STEP_TIME:     dt_ff      <= csr_data[30:0];
            REG_BOX_HALF_SIZE: box_ff     <= csr_data[30:0];
            REG_WALL_MARGIN:   margin_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [31:0] pin [AXES];
      logic signed [31:0] vin [AXES];
      logic [31:0]        av;
      logic [30:0]        kk;
      logic [30:0]        d;
      logic signed [35:0] nm, sum, drag;
      logic [31:0]        r2;
      logic signed [31:0] q;

      pin[0] = req_data.pos_x; pin[1] = req_data.pos_y; pin[2] = req_data.pos_z;
      vin[0] = req_data.vel_x; vin[1] = req_data.vel_y; vin[2] = req_data.vel_z;

      // entry: cd*rho, v squared, wall test
      st_in[0]        = '0;
      st_in[0].c.valid = start && !busy;
      st_in[0].c.mass = req_data.body_mass;
      st_in[0].c.area = req_data.frontal_area;
      st_in[0].c.cr   = req_data.restitution;
      st_in[0].c.prod = 62'(req_data.drag_coef) * 62'(rho_ff);
      for (int a = 0; a < AXES; a++) begin
         av = mag32(vin[a]);
         st_in[0].lane[a].pos  = pin[a];
         st_in[0].lane[a].vel  = vin[a];
         st_in[0].lane[a].prod = 64'(av) * 64'(av);
         st_in[0].lane[a].apos = mag32(pin[a]);
         st_in[0].lane[a].hit  = ({2'b0, mag32(pin[a])} + {3'b0, req_data.body_radius})
                                 > {3'b0, box_ff};
         st_in[0].lane[a].far  = $signed({2'b0, box_ff}) - $signed({2'b0, req_data.body_radius})
                                 - $signed({2'b0, margin_ff});
      end

      for (int s = 1; s < NSTAGE; s++)
         st_in[s] = st_ff[s-1];

      // k partial times area, v squared clamp, mirrored position
      kk = (|st_ff[0].c.prod[61:47]) ? POS_MAX31 : st_ff[0].c.prod[46:16];
      st_in[1].c.prod = 62'(kk) * 62'(st_ff[0].c.area);
      for (int a = 0; a < AXES; a++) begin
         st_in[1].lane[a].f = (|st_ff[0].lane[a].prod[63:47]) ? POS_MAX31
                              : st_ff[0].lane[a].prod[46:16];
         nm = $signed({{2{st_ff[0].lane[a].far[32]}}, st_ff[0].lane[a].far, 1'b0})
              - $signed({4'b0, st_ff[0].lane[a].apos});
         if (st_ff[0].lane[a].hit)
            st_in[1].lane[a].pos = sat36(st_ff[0].lane[a].pos[31] ? -nm : nm);
      end

      // force = sq * k
      kk = (|st_ff[1].c.prod[61:47]) ? POS_MAX31 : st_ff[1].c.prod[46:16];
      for (int a = 0; a < AXES; a++)
         st_in[2].lane[a].prod = 64'(st_ff[1].lane[a].f) * 64'(kk);

      // divider setup: quotient fits 31 bits unless f >= mass * 2^15
      for (int a = 0; a < AXES; a++) begin
         st_in[3].lane[a].f   = (|st_ff[2].lane[a].prod[63:47]) ? POS_MAX31
                                : st_ff[2].lane[a].prod[46:16];
         st_in[3].lane[a].fz  = (st_in[3].lane[a].f == '0);
         st_in[3].lane[a].ovf = {15'b0, st_in[3].lane[a].f} >= {st_ff[2].c.mass, 15'b0};
         st_in[3].lane[a].rem = {16'b0, st_in[3].lane[a].f[30:15]};
         st_in[3].lane[a].nsh = {st_in[3].lane[a].f[14:0], 16'b0};
         st_in[3].lane[a].quo = '0;
      end

      // one quotient bit per stage
      for (int t = 0; t < DIV_BITS; t++) begin
         for (int a = 0; a < AXES; a++) begin
            r2 = {st_ff[DIV_FIRST+t-1].lane[a].rem[30:0], st_ff[DIV_FIRST+t-1].lane[a].nsh[30]};
            st_in[DIV_FIRST+t].lane[a].nsh = {st_ff[DIV_FIRST+t-1].lane[a].nsh[29:0], 1'b0};
            if (r2 >= {1'b0, st_ff[DIV_FIRST+t-1].c.mass}) begin
               st_in[DIV_FIRST+t].lane[a].rem = r2 - {1'b0, st_ff[DIV_FIRST+t-1].c.mass};
               st_in[DIV_FIRST+t].lane[a].quo = {st_ff[DIV_FIRST+t-1].lane[a].quo[29:0], 1'b1};
            end else begin
               st_in[DIV_FIRST+t].lane[a].rem = r2;
               st_in[DIV_FIRST+t].lane[a].quo = {st_ff[DIV_FIRST+t-1].lane[a].quo[29:0], 1'b0};
            end
         end
      end

      // drag opposes velocity, acceleration
      for (int a = 0; a < AXES; a++) begin
         d = st_ff[34].lane[a].fz ? '0
             : (st_ff[34].lane[a].ovf ? POS_MAX31 : st_ff[34].lane[a].quo);
         if (st_ff[34].lane[a].vel == '0)
            drag = '0;
         else if (st_ff[34].lane[a].vel[31])
            drag = $signed({5'b0, d});
         else
            drag = -$signed({5'b0, d});
         sum = $signed({{4{grav_ff[a][31]}}, grav_ff[a]}) + drag;
         st_in[35].lane[a].acc = sat36(sum);
      end

      for (int a = 0; a < AXES; a++)
         st_in[36].lane[a].prod = 64'(mag32(st_ff[35].lane[a].acc)) * 64'(dt_ff);

      // v1 and bounce decision
      for (int a = 0; a < AXES; a++) begin
         q = qmul_finish(st_ff[36].lane[a].acc[31], st_ff[36].lane[a].prod);
         sum = $signed({{4{st_ff[36].lane[a].vel[31]}}, st_ff[36].lane[a].vel})
               + $signed({{4{q[31]}}, q});
         st_in[37].lane[a].vel = sat36(sum);
         st_in[37].lane[a].bnc = st_ff[36].lane[a].hit
                                 && (st_ff[36].lane[a].pos[31] == st_in[37].lane[a].vel[31]);
      end

      for (int a = 0; a < AXES; a++)
         st_in[38].lane[a].prod = 64'(mag32(st_ff[37].lane[a].vel)) * 64'(st_ff[37].c.cr);

      // outward velocity scaled by -cr
      for (int a = 0; a < AXES; a++)
         if (st_ff[38].lane[a].bnc)
            st_in[39].lane[a].vel = qmul_finish(!st_ff[38].lane[a].vel[31],
                                                st_ff[38].lane[a].prod);

      for (int a = 0; a < AXES; a++)
         st_in[40].lane[a].prod = 64'(mag32(st_ff[39].lane[a].vel)) * 64'(dt_ff);

      for (int a = 0; a < AXES; a++) begin
         q = qmul_finish(st_ff[40].lane[a].vel[31], st_ff[40].lane[a].prod);
         sum = $signed({{4{st_ff[40].lane[a].pos[31]}}, st_ff[40].lane[a].pos})
               + $signed({{4{q[31]}}, q});
         st_in[41].lane[a].pos = sat36(sum);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NSTAGE; s++) begin
         if (reset)
            st_ff[s].c.valid <= 1'b0;
         else
            st_ff[s] <= st_in[s];
      end
   end

   assign rsp_valid           = st_ff[NSTAGE-1].c.valid;
   assign rsp_data.new_pos_x  = st_ff[NSTAGE-1].lane[0].pos;
   assign rsp_data.new_pos_y  = st_ff[NSTAGE-1].lane[1].pos;
   assign rsp_data.new_pos_z  = st_ff[NSTAGE-1].lane[2].pos;
   assign rsp_data.new_vel_x  = st_ff[NSTAGE-1].lane[0].vel;
   assign rsp_data.new_vel_y  = st_ff[NSTAGE-1].lane[1].vel;
   assign rsp_data.new_vel_z  = st_ff[NSTAGE-1].lane[2].vel;
   assign rsp_data.wall_hits  = {st_ff[NSTAGE-1].lane[2].hit, st_ff[NSTAGE-1].lane[1].hit,
                                 st_ff[NSTAGE-1].lane[0].hit};

   // every accepted request is followed by rsp_valid a fixed latency later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##41 rsp_valid)
      else $error("request lost in pipe");

   // a bounce only happens on an axis that touched the wall
   a_bounce_hit: assert property (@(posedge clock) disable iff (reset)
      st_ff[38].c.valid |-> ((!st_ff[38].lane[0].bnc || st_ff[38].lane[0].hit)
                          && (!st_ff[38].lane[1].bnc || st_ff[38].lane[1].hit)
                          && (!st_ff[38].lane[2].bnc || st_ff[38].lane[2].hit)))
      else $error("bounce without wall hit");

   // lane 0 partial remainder at the first divider stage stays below the mass when the quotient is in range
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (st_ff[DIV_FIRST].c.valid && !st_ff[DIV_FIRST].lane[0].ovf)
      |-> (st_ff[DIV_FIRST].lane[0].rem < {1'b0, st_ff[DIV_FIRST].c.mass}))
      else $error("divider remainder out of range");

endmodule
